FILE: rtl/sde_pkg.sv
// Shared constants, types and codes of the sample-to-delta instruction encoder.
`timescale 1ns / 1ps

package sde_pkg;

    localparam int TIME_W           = 32;
    localparam int MASK_BITS        = 8;
    localparam int AMP_W            = 7;
    localparam int CHAN_IDX_W       = 3;
    localparam int AMP_SCALE        = 10;
    localparam int AMP_VAL_W        = 11;
    localparam int AMP_VALUE_MAX    = 1270;
    localparam int CHANNELS_DEFAULT = 8;
    localparam int QUEUE_DEPTH      = 2;

    // Pending work of one sample: bit 0 is the time increment, bit i+1 is channel i.
    localparam int PEND_BITS = MASK_BITS + 1;
    localparam int PEND_IDX_W = $clog2(PEND_BITS);

    localparam logic KIND_TIME = 1'b0;
    localparam logic KIND_AMP  = 1'b1;

    typedef struct packed {
        logic                  time_emit;
        logic [TIME_W-1:0]     delta;
        logic [MASK_BITS-1:0]  ch_emit;
        logic [MASK_BITS-1:0]  on_mask;
        logic [AMP_VAL_W-1:0]  amp_value;
    } sde_job_t;

endpackage

FILE: rtl/sde_ifs.sv
// Stream interfaces for sample beats and instruction beats.
`timescale 1ns / 1ps

interface sde_sample_if
    import sde_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [TIME_W-1:0]    sample_time_ms;
    logic [MASK_BITS-1:0] channel_mask;
    logic [AMP_W-1:0]     amplitude_pct;
    logic                 start_of_pattern;

    modport source (output valid, sample_time_ms, channel_mask, amplitude_pct,
                    start_of_pattern, input ready);
    modport sink   (input valid, sample_time_ms, channel_mask, amplitude_pct,
                    start_of_pattern, output ready);
endinterface

interface sde_instr_if
    import sde_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  instr_kind;
    logic [CHAN_IDX_W-1:0] channel_index;
    logic [TIME_W-1:0]     instr_value;
    logic                  last_of_run;

    modport source (output valid, instr_kind, channel_index, instr_value, last_of_run,
                    input ready);
    modport sink   (input valid, instr_kind, channel_index, instr_value, last_of_run,
                    output ready);
endinterface

FILE: rtl/sde_front.sv
// Front end: accepts samples, compares them with the previous one and builds jobs.
`timescale 1ns / 1ps

module sde_front
    import sde_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    sde_sample_if.sink   sample,
    output sde_job_t     job,
    output logic         job_valid,
    input  logic         job_ready
);

    localparam int EMIT_CH = (CHANNELS < MASK_BITS) ? CHANNELS : MASK_BITS;

    logic [TIME_W-1:0]    prev_time_reg;
    logic [MASK_BITS-1:0] prev_mask_reg;
    logic [AMP_W-1:0]     prev_amp_reg;

    logic [TIME_W-1:0]    prev_time_eff;
    logic [MASK_BITS-1:0] prev_mask_eff;
    logic [AMP_W-1:0]     prev_amp_eff;
    logic                 amp_changed;
    logic                 accept;

    always_comb
    begin
        prev_time_eff = sample.start_of_pattern ? '0 : prev_time_reg;
        prev_mask_eff = sample.start_of_pattern ? '0 : prev_mask_reg;
        prev_amp_eff  = sample.start_of_pattern ? '0 : prev_amp_reg;
        amp_changed   = (sample.amplitude_pct != prev_amp_eff);

        job.delta     = sample.sample_time_ms - prev_time_eff;
        job.time_emit = (job.delta != '0);
        job.on_mask   = sample.channel_mask;
        job.amp_value = AMP_VAL_W'(sample.amplitude_pct) * AMP_VAL_W'(AMP_SCALE);
        for (int i = 0; i < MASK_BITS; i++)
        begin
            if (i < EMIT_CH)
            begin
                job.ch_emit[i] = (sample.channel_mask[i] != prev_mask_eff[i])
                               || (sample.channel_mask[i] && amp_changed);
            end
            else
            begin
                job.ch_emit[i] = 1'b0;
            end
        end

        // A sample that changes nothing is taken but leaves no job behind.
        job_valid    = sample.valid && (job.time_emit || (job.ch_emit != '0));
        sample.ready = job_ready;
        accept       = sample.valid && job_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
            prev_mask_reg <= '0;
            prev_amp_reg  <= '0;
        end
        else if (accept)
        begin
            prev_time_reg <= sample.sample_time_ms;
            prev_mask_reg <= sample.channel_mask;
            prev_amp_reg  <= sample.amplitude_pct;
        end
    end

endmodule

FILE: rtl/sde_queue.sv
// Short job queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module sde_queue
    import sde_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic     clk,
    input  logic     rst_n,
    input  sde_job_t push_job,
    input  logic     push_valid,
    output logic     push_ready,
    output sde_job_t pop_job,
    output logic     pop_valid,
    input  logic     pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sde_job_t         slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    always_comb
    begin
        push_ready = (count_reg != CNT_W'(DEPTH));
        pop_valid  = (count_reg != '0);
        pop_job    = slots[rd_ptr_reg];
        do_push    = push_valid && push_ready;
        do_pop     = pop_valid && pop_ready;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end

        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/sde_back.sv
// Back end: serializes the pending instructions of one job, one beat per cycle unless the receiver stalls.
`timescale 1ns / 1ps

module sde_back
    import sde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sde_job_t    job,
    input  logic        job_valid,
    output logic        job_ready,
    sde_instr_if.source instr
);

    // Working job.
    logic                 work_valid_reg, work_valid_next;
    logic [PEND_BITS-1:0] pend_reg, pend_next;
    logic [TIME_W-1:0]    delta_reg;
    logic [MASK_BITS-1:0] on_mask_reg;
    logic [AMP_VAL_W-1:0] amp_value_reg;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic                  out_kind_reg;
    logic [CHAN_IDX_W-1:0] out_chan_reg;
    logic [TIME_W-1:0]     out_value_reg;
    logic                  out_last_reg;

    logic                  advance;
    logic                  emit;
    logic                  load;
    logic [PEND_BITS-1:0]  pend_rest;
    logic [PEND_IDX_W-1:0] sel_idx;
    logic [CHAN_IDX_W-1:0] sel_chan;
    logic                  sel_kind;
    logic [TIME_W-1:0]     sel_value;

    always_comb
    begin
        advance = !out_valid_reg || instr.ready;
        emit    = work_valid_reg && advance;

        // Lowest pending bit wins: time first, then channels in ascending order.
        sel_idx = '0;
        for (int i = PEND_BITS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                sel_idx = PEND_IDX_W'(i);
            end
        end
        pend_rest = pend_reg & (pend_reg - 1'b1);

        sel_kind  = (sel_idx == '0) ? KIND_TIME : KIND_AMP;
        sel_chan  = (sel_idx == '0) ? '0 : CHAN_IDX_W'(sel_idx - 1'b1);
        if (sel_idx == '0)
        begin
            sel_value = delta_reg;
        end
        else if (on_mask_reg[sel_chan])
        begin
            sel_value = TIME_W'(amp_value_reg);
        end
        else
        begin
            sel_value = '0;
        end

        job_ready = !work_valid_reg || (emit && (pend_rest == '0));
        load      = job_valid && job_ready;

        work_valid_next = work_valid_reg;
        pend_next       = pend_reg;
        if (emit)
        begin
            pend_next       = pend_rest;
            work_valid_next = (pend_rest != '0);
        end
        if (load)
        begin
            pend_next       = {job.ch_emit, job.time_emit};
            work_valid_next = 1'b1;
        end

        out_valid_next = emit ? 1'b1 : (out_valid_reg && !instr.ready);

        instr.valid         = out_valid_reg;
        instr.instr_kind    = out_kind_reg;
        instr.channel_index = out_chan_reg;
        instr.instr_value   = out_value_reg;
        instr.last_of_run   = out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            delta_reg     <= job.delta;
            on_mask_reg   <= job.on_mask;
            amp_value_reg <= job.amp_value;
        end
        if (emit)
        begin
            out_kind_reg  <= sel_kind;
            out_chan_reg  <= sel_chan;
            out_value_reg <= sel_value;
            out_last_reg  <= (pend_rest == '0);
        end
    end

endmodule

FILE: rtl/sample_to_delta_instruction_encoder_unit.sv
// Top level of the sample-to-delta instruction encoder.
`timescale 1ns / 1ps
//
// The block turns a stream of haptic samples into decoded instructions.
// Channel sample: one beat per sample (timestamp, channel-on mask, amplitude
// percent, start flag). Channel instr: one beat per instruction (kind, channel
// index, value, last flag). Both use valid/ready; a beat moves when both are high.
// For each sample the block emits a time increment when the timestamp moved
// (delta modulo 2^32), then one set-amplitude beat per changed channel in
// ascending order. A sample that changes nothing yields no beat. last_of_run
// marks the final beat of a sample.
// The first beat of a sample passes the job queue, the back end's working job
// and its output register before it is presented on instr.
// Throughput: unless the receiver stalls, the back end sends one beat per
// cycle, and a sample yields up to nine beats; the front end takes one
// sample per cycle while the two-entry job queue has room.
// Reset clears the previous sample to zeros and empties the queue and the
// output register. When the receiver stalls, the output beat holds, the back
// end waits, the queue fills and then sample.ready drops.

module sample_to_delta_instruction_encoder_unit
    import sde_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEFAULT,
    parameter int QUEUE_SLOTS = QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    sde_sample_if.sink  sample,
    sde_instr_if.source instr
);

    sde_job_t front_job;
    logic     front_valid;
    logic     front_ready;
    sde_job_t back_job;
    logic     back_valid;
    logic     back_ready;

    // Front end: compares each sample with the previous one.
    sde_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    // Jobs wait here so that the front end keeps taking samples during a run.
    sde_queue #(
        .DEPTH (QUEUE_SLOTS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (front_job),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_job    (back_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    // Back end: one instruction beat per cycle from the working job unless instr stalls.
    sde_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .instr     (instr)
    );

endmodule

FILE: rtl/sde_checker.sv
// Port-level checks of the encoder, bound to the top level.
`timescale 1ns / 1ps

module sde_checker
    import sde_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  instr_valid,
    input logic                  instr_ready,
    input logic                  instr_kind,
    input logic [CHAN_IDX_W-1:0] channel_index,
    input logic [TIME_W-1:0]     instr_value
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        instr_valid && !instr_ready |=> instr_valid)
        else $error("instruction beat dropped while stalled");

    a_time_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        instr_valid && (instr_kind == KIND_TIME) |-> (channel_index == '0))
        else $error("time increment carries a channel index");

    a_time_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        instr_valid && (instr_kind == KIND_TIME) |-> (instr_value != '0))
        else $error("time increment of zero emitted");

    a_amp_range: assert property (@(posedge clk) disable iff (!rst_n)
        instr_valid && (instr_kind == KIND_AMP) |-> (instr_value <= TIME_W'(AMP_VALUE_MAX)))
        else $error("amplitude value out of range");

endmodule

bind sample_to_delta_instruction_encoder_unit sde_checker u_sde_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .instr_valid   (instr.valid),
    .instr_ready   (instr.ready),
    .instr_kind    (instr.instr_kind),
    .channel_index (instr.channel_index),
    .instr_value   (instr.instr_value)
);
